@@ src/ostst_pkg.sv @@
// ----------------------------------------------------------------------------
// ostst_pkg
// Shared widths, request and status codes and the table write command of the
// one-shot timer slot table.
// ----------------------------------------------------------------------------
package ostst_pkg;

    localparam int TIMER_SLOTS   = 10;
    localparam int NUM_SLOTS_DEF = TIMER_SLOTS;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int TICK_W   = 32;
    localparam int TAG_W    = 16;
    localparam int ARG_W    = 32;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] idx;
    } ostst_wr_t;

endpackage

@@ src/ostst_slot_table.sv @@
// ----------------------------------------------------------------------------
// ostst_slot_table
// Slot storage: occupied bits in flops cleared by reset, and deadline, tag
// and argument per slot, read at the scan index.
// ----------------------------------------------------------------------------
module ostst_slot_table #(
    parameter int NUM_SLOTS = ostst_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ostst_pkg::ostst_wr_t           wr,
    input  logic [ostst_pkg::TICK_W-1:0]   wr_deadline,
    input  logic [ostst_pkg::TAG_W-1:0]    wr_tag,
    input  logic [ostst_pkg::ARG_W-1:0]    wr_arg,
    input  logic [ostst_pkg::SLOT_W-1:0]   rd_idx,
    output logic                           rd_valid,
    output logic [ostst_pkg::TICK_W-1:0]   rd_deadline,
    output logic [ostst_pkg::TAG_W-1:0]    rd_tag,
    output logic [ostst_pkg::ARG_W-1:0]    rd_arg
);
    import ostst_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [TICK_W-1:0]    deadline_mem [NUM_SLOTS];
    logic [TAG_W-1:0]     tag_mem      [NUM_SLOTS];
    logic [ARG_W-1:0]     arg_mem      [NUM_SLOTS];

    logic [IDX_W-1:0] wr_sel;
    logic [IDX_W-1:0] rd_sel;

    assign wr_sel = wr.idx[IDX_W-1:0];
    assign rd_sel = rd_idx[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.set)
        begin
            valid_reg[wr_sel] <= 1'b1;
        end
        else if (wr.clr)
        begin
            valid_reg[wr_sel] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.set)
        begin
            deadline_mem[wr_sel] <= wr_deadline;
            tag_mem[wr_sel]      <= wr_tag;
            arg_mem[wr_sel]      <= wr_arg;
        end
    end

    assign rd_valid    = valid_reg[rd_sel];
    assign rd_deadline = deadline_mem[rd_sel];
    assign rd_tag      = tag_mem[rd_sel];
    assign rd_arg      = arg_mem[rd_sel];

endmodule

@@ src/one_shot_timer_slot_table_core.sv @@
// ----------------------------------------------------------------------------
// one_shot_timer_slot_table_core
// Tick counter and table of one-shot timer slots with create, delete and
// tick requests, one result item per request item.
// ----------------------------------------------------------------------------
// A request item is taken only while the block is idle. Tick and valid create
// items walk the slots one per cycle and stop at the first hit: a tick at an
// occupied slot whose deadline the single deadline comparator finds reached, a
// create at a free slot. Delete, rejected create and unknown items skip the scan.
// The result item sits in an output register; a waiting result holds back
// only the end of the following item's scan, not its acceptance.
module one_shot_timer_slot_table_core #(
    parameter int NUM_SLOTS = ostst_pkg::NUM_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ostst_pkg::REQ_W-1:0]      req_type,
    input  logic [ostst_pkg::TICK_W-1:0]     delay_ticks,
    input  logic [ostst_pkg::SLOT_W-1:0]     slot_index,
    input  logic [ostst_pkg::TAG_W-1:0]      callback_tag,
    input  logic [ostst_pkg::ARG_W-1:0]      callback_arg,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ostst_pkg::STATUS_W-1:0]   status,
    output logic [ostst_pkg::SLOT_W-1:0]     alloc_slot,
    output logic                             fired,
    output logic [ostst_pkg::SLOT_W-1:0]     fired_slot,
    output logic [ostst_pkg::TAG_W-1:0]      fired_tag,
    output logic [ostst_pkg::ARG_W-1:0]      fired_arg
);
    import ostst_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                create_reg, create_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [TICK_W-1:0]   new_deadline_reg, new_deadline_next;
    logic [TAG_W-1:0]    new_tag_reg, new_tag_next;
    logic [ARG_W-1:0]    new_arg_reg, new_arg_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_alloc_reg, res_alloc_next;
    logic                res_fired_reg, res_fired_next;
    logic [SLOT_W-1:0]   res_fslot_reg, res_fslot_next;
    logic [TAG_W-1:0]    res_ftag_reg, res_ftag_next;
    logic [ARG_W-1:0]    res_farg_reg, res_farg_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   alloc_reg, alloc_next;
    logic                fired_reg, fired_next;
    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic [TAG_W-1:0]    ftag_reg, ftag_next;
    logic [ARG_W-1:0]    farg_reg, farg_next;

    ostst_wr_t           wr;
    logic                rd_valid;
    logic [TICK_W-1:0]   rd_deadline;
    logic [TAG_W-1:0]    rd_tag;
    logic [ARG_W-1:0]    rd_arg;
    logic                scan_last;
    logic                reached;
    logic                del_in_range;

    ostst_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .wr_deadline (new_deadline_reg),
        .wr_tag      (new_tag_reg),
        .wr_arg      (new_arg_reg),
        .rd_idx      (SLOT_W'(scan_idx_reg)),
        .rd_valid    (rd_valid),
        .rd_deadline (rd_deadline),
        .rd_tag      (rd_tag),
        .rd_arg      (rd_arg)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign scan_last    = (scan_idx_reg == IDX_W'(NUM_SLOTS - 1));
    // shared deadline comparator
    assign reached      = (tick_reg >= rd_deadline);
    assign del_in_range = ({1'b0, slot_index} < (SLOT_W + 1)'(NUM_SLOTS));

    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        create_next       = create_reg;
        tick_next         = tick_reg;
        new_deadline_next = new_deadline_reg;
        new_tag_next      = new_tag_reg;
        new_arg_next      = new_arg_reg;
        res_status_next   = res_status_reg;
        res_alloc_next    = res_alloc_reg;
        res_fired_next    = res_fired_reg;
        res_fslot_next    = res_fslot_reg;
        res_ftag_next     = res_ftag_reg;
        res_farg_next     = res_farg_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        alloc_next        = alloc_reg;
        fired_next        = fired_reg;
        fslot_next        = fslot_reg;
        ftag_next         = ftag_reg;
        farg_next         = farg_reg;
        wr                = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_alloc_next  = '0;
                    res_fired_next  = 1'b0;
                    res_fslot_next  = '0;
                    res_ftag_next   = '0;
                    res_farg_next   = '0;
                    scan_idx_next   = '0;
                    create_next     = 1'b0;
                    state_next      = S_FINISH;
                    case (req_type)
                        REQ_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                        REQ_CREATE:
                        begin
                            if (callback_tag == '0 || delay_ticks == '0)
                            begin
                                res_status_next = ST_BAD;
                            end
                            else
                            begin
                                create_next       = 1'b1;
                                new_deadline_next = tick_reg + delay_ticks;
                                new_tag_next      = callback_tag;
                                new_arg_next      = callback_arg;
                                state_next        = S_SCAN;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (del_in_range)
                            begin
                                wr.clr = 1'b1;
                                wr.idx = slot_index;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (create_reg && !rd_valid)
                begin
                    wr.set         = 1'b1;
                    wr.idx         = SLOT_W'(scan_idx_reg);
                    res_alloc_next = SLOT_W'(scan_idx_reg);
                    state_next     = S_FINISH;
                end
                else if (!create_reg && rd_valid && reached)
                begin
                    wr.clr         = 1'b1;
                    wr.idx         = SLOT_W'(scan_idx_reg);
                    res_fired_next = 1'b1;
                    res_fslot_next = SLOT_W'(scan_idx_reg);
                    res_ftag_next  = rd_tag;
                    res_farg_next  = rd_arg;
                    state_next     = S_FINISH;
                end
                else if (scan_last)
                begin
                    if (create_reg)
                    begin
                        res_status_next = ST_FULL;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    alloc_next     = res_alloc_reg;
                    fired_next     = res_fired_reg;
                    fslot_next     = res_fslot_reg;
                    ftag_next      = res_ftag_reg;
                    farg_next      = res_farg_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            scan_idx_reg     <= '0;
            create_reg       <= 1'b0;
            tick_reg         <= '0;
            new_deadline_reg <= '0;
            new_tag_reg      <= '0;
            new_arg_reg      <= '0;
            res_status_reg   <= ST_OK;
            res_alloc_reg    <= '0;
            res_fired_reg    <= 1'b0;
            res_fslot_reg    <= '0;
            res_ftag_reg     <= '0;
            res_farg_reg     <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= ST_OK;
            alloc_reg        <= '0;
            fired_reg        <= 1'b0;
            fslot_reg        <= '0;
            ftag_reg         <= '0;
            farg_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            create_reg       <= create_next;
            tick_reg         <= tick_next;
            new_deadline_reg <= new_deadline_next;
            new_tag_reg      <= new_tag_next;
            new_arg_reg      <= new_arg_next;
            res_status_reg   <= res_status_next;
            res_alloc_reg    <= res_alloc_next;
            res_fired_reg    <= res_fired_next;
            res_fslot_reg    <= res_fslot_next;
            res_ftag_reg     <= res_ftag_next;
            res_farg_reg     <= res_farg_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            alloc_reg        <= alloc_next;
            fired_reg        <= fired_next;
            fslot_reg        <= fslot_next;
            ftag_reg         <= ftag_next;
            farg_reg         <= farg_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign alloc_slot = alloc_reg;
    assign fired      = fired_reg;
    assign fired_slot = fslot_reg;
    assign fired_tag  = ftag_reg;
    assign fired_arg  = farg_reg;

    // a fired result never reports an allocation or an error
    a_fired_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> status == ST_OK && alloc_slot == '0)
        else $error("fired result with status or alloc set");

    // the scan pointer stays within the table
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg <= IDX_W'(NUM_SLOTS - 1))
        else $error("scan index beyond last slot");

    // the counter moves only on an accepted tick item
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall && req_type == REQ_TICK) |=> $stable(tick_reg))
        else $error("tick count changed without tick item");

    // at most one slot is written per cycle
    a_wr_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.set && wr.clr))
        else $error("table set and clear together");

endmodule
